// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types, constants and helper functions of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hc3d2e1f0;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [6:0] LenStart  = 7'd56;
  localparam logic [6:0] FullLess1 = 7'd63;
  localparam logic [2:0] LastWord  = 3'd4;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_PAD,
    PH_DONE
  } phase_e;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0:    r = H0Init;
      3'd1:    r = H1Init;
      3'd2:    r = H2Init;
      3'd3:    r = H3Init;
      default: r = H4Init;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sha1_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher channels
// Valid/ready interfaces for message items and digest words.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message items, drops idle ones and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sha1_front #(
  parameter int unsigned Depth = sha1_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sha1_in_if.sink         in_i,
  output logic            item_valid_o,
  output sha1_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import sha1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_i.ready   = (cnt_q != CntW'(Depth));
  assign push         = in_i.valid && in_i.ready && (in_i.byte_present || in_i.end_of_message);
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{msg_byte: in_i.msg_byte, byte_present: in_i.byte_present,
                       end_of_message: in_i.end_of_message};
    end
  end

endmodule

// ===== sv/sha1_back.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine
// Packs bytes, pads, runs the 80-round compression and emits the digest.
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  sha1_pkg::item_t item_i,
  output logic            item_ready_o,
  sha1_out_if.source      out_o
);
  import sha1_pkg::*;

  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [511:0] buf_q, buf_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [63:0]  bits_q, bits_d;
  logic         eom_q, eom_d;
  logic [2:0]   idx_q, idx_d;
  logic [31:0]  h_q [5];
  logic [31:0]  h_d [5];
  logic [31:0]  v_q [5];
  logic [31:0]  v_d [5];

  logic [31:0] w0, w2, w8, w13, sx, f, k, tmp;

  assign w0  = buf_q[511:480];
  assign w2  = buf_q[447:416];
  assign w8  = buf_q[255:224];
  assign w13 = buf_q[95:64];
  assign sx  = w13 ^ w8 ^ w2 ^ w0;

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (v_q[1] & v_q[2]) ^ (~v_q[1] & v_q[3]);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (v_q[1] & v_q[2]) ^ (v_q[1] & v_q[3]) ^ (v_q[2] & v_q[3]);
      k = K2;
    end else begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = K3;
    end
    tmp = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + w0;
  end

  assign item_ready_o      = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == LastWord);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    bits_d  = bits_q;
    eom_d   = eom_q;
    idx_d   = idx_q;
    h_d     = h_q;
    v_d     = v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          eom_d   = item_i.end_of_message;
          phase_d = PH_MSG;
          if (item_i.byte_present) begin
            buf_d  = {buf_q[503:0], item_i.msg_byte};
            cnt_d  = cnt_q + 1'b1;
            bits_d = bits_q + 64'd8;
          end
          if (item_i.byte_present && cnt_q == FullLess1) begin
            state_d = ST_ROUND;
            v_d     = h_q;
            rnd_d   = '0;
          end else if (item_i.end_of_message) begin
            state_d = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        buf_d   = {buf_q[503:0], PadByte};
        cnt_d   = cnt_q + 1'b1;
        phase_d = PH_PAD;
        if (cnt_q == FullLess1) begin
          state_d = ST_ROUND;
          v_d     = h_q;
          rnd_d   = '0;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (cnt_q == LenStart) begin
          state_d = ST_LEN;
        end else begin
          buf_d = {buf_q[503:0], 8'h00};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == FullLess1) begin
            state_d = ST_ROUND;
            v_d     = h_q;
            rnd_d   = '0;
          end
        end
      end
      ST_LEN: begin
        buf_d  = {buf_q[503:0], bits_q[63:56]};
        bits_d = {bits_q[55:0], 8'h00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == FullLess1) begin
          phase_d = PH_DONE;
          state_d = ST_ROUND;
          v_d     = h_q;
          rnd_d   = '0;
        end
      end
      ST_ROUND: begin
        buf_d  = {buf_q[479:0], sx[30:0], sx[31]};
        v_d[4] = v_q[3];
        v_d[3] = v_q[2];
        v_d[2] = {v_q[1][1:0], v_q[1][31:2]};
        v_d[1] = v_q[0];
        v_d[0] = tmp;
        rnd_d  = rnd_q + 1'b1;
        if (rnd_q == LastRound) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        cnt_d = '0;
        unique case (phase_q)
          PH_MSG:  state_d = eom_q ? ST_PAD80 : ST_IDLE;
          PH_PAD:  state_d = ST_ZERO;
          default: begin
            state_d = ST_OUT;
            idx_d   = '0;
          end
        endcase
      end
      ST_OUT: begin
        if (out_o.ready) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LastWord) begin
            state_d = ST_IDLE;
            bits_d  = '0;
            for (int i = 0; i < 5; i++) begin
              h_d[i] = init_word(3'(i));
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MSG;
      cnt_q   <= '0;
      rnd_q   <= '0;
      bits_q  <= '0;
      eom_q   <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < 5; i++) begin
        h_q[i] <= init_word(3'(i));
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      bits_q  <= bits_d;
      eom_q   <= eom_d;
      idx_q   <= idx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    v_q   <= v_d;
  end

endmodule

// ===== sv/sha1_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// Streaming SHA-1 hasher
// Hashes a byte stream and emits the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_i     in   msg_byte[7:0], byte_present, end_of_message
// out_o    out  digest_word[31:0], word_index[2:0], last_word
//
// A byte is packed per accepted item; every 64th byte starts the rounds and
// the chaining update, all in the single round unit of the engine, which takes
// no new item until they finish. Closing a message adds padding one byte at a
// time, one or two compressions and the output of the five digest words.
// The input queue keeps taking transactions while the engine works or the
// digest output stalls, until its entries are full. Reset restores the
// initial hash values.
module sha1_stream_hasher_core #(
  parameter int unsigned QueueDepth = sha1_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);
  import sha1_pkg::*;

  logic  item_valid, item_ready;
  item_t item;

  sha1_front #(.Depth(QueueDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_ready_i(item_ready)
  );

  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_ready_o(item_ready),
    .out_o       (out_o)
  );

endmodule
